// ----- src/resp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_pkg: shared types and constants of the RESP command parser
// Result kinds, error codes, parser phases, register indexes and the byte
// codes of the framing characters.
// ----------------------------------------------------------------------------
package resp_pkg;

  // Largest argument count the parser will ever accept.
  localparam logic [6:0] MAX_ARGS = 7'd64;

  // Length lines are limited to one less than this many characters, the CR not counted.
  localparam int LEN_LINE_LIMIT = 32;
  localparam int LCNT_W = $clog2(LEN_LINE_LIMIT);

  // Length accumulator saturates at its all-ones value.
  localparam int ACC_W = 25;
  localparam logic [ACC_W-1:0] ACC_CAP = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_CAP_DIV10 = ACC_W'(ACC_CAP / 10);

  // Configuration port.
  localparam int CFG_DATA_W = 24;
  localparam logic CFG_MAX_BULK_LEN = 1'b0;
  localparam logic CFG_MAX_ARGS = 1'b1;
  localparam logic [23:0] MAX_BULK_LEN_RST = 24'hFFFFFF;

  // Framing characters.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_ARG_END = 3'd2,
    KIND_CMD_END = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_TYPE    = 3'd1,
    ERR_LINE_LONG   = 3'd2,
    ERR_BAD_TERM    = 3'd3,
    ERR_RANGE       = 3'd4,
    ERR_OUTSIDE_ARR = 3'd5
  } err_e;

  typedef enum logic [5:0] {
    PH_TYPE    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_LEN_LF  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_PAY_CR  = 6'b010000,
    PH_PAY_LF  = 6'b100000
  } phase_e;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic [23:0] len;
    logic        is_null;
    logic [6:0]  total;
    err_e        err;
  } res_t;

endpackage
`default_nettype wire

// ----- src/resp_command_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_command_parser: byte-serial parser for RESP arrays of bulk strings
// Usage: the request stream enters one byte per beat on the input channel
// (in_valid_i / in_stall_o / byte_in_i). Every accepted byte produces exactly
// one result beat on the output channel (out_valid_o / out_stall_i): a payload
// byte, an argument end, a command end, an error, or nothing. error_code_o
// carries the sticky error state on every beat; after an error all further
// beats are of kind nothing until reset.
// A result beat is computed from the input register and offered from the result
// register, so each accepted byte passes through both in that order.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat, the input
// register keeps one more byte, and only then is in_stall_o raised.
// Reset clears the parser state, drops any buffered beats and loads the
// limits with their defaults (largest bulk length 16777215, 64 arguments).
// Limit writes via cfg_we_i / cfg_index_i / cfg_wdata_i take effect at once;
// the user writes them only while the channels are idle; it is not checked.
// ----------------------------------------------------------------------------
module resp_command_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request byte channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    byte_in_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         kind_o,
  output logic [7:0]                         data_byte_o,
  output logic [5:0]                         arg_index_o,
  output logic [23:0]                        arg_length_o,
  output logic                               arg_is_null_o,
  output logic [6:0]                         arg_total_o,
  output logic [2:0]                         error_code_o,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [resp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import resp_pkg::*;

  // Handshake and pipeline registers.
  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  res_t             res_q, res_d;
  logic             out_ready;
  logic             advance;

  // Limit registers.
  logic [23:0]      max_bulk_q;
  logic [6:0]       max_args_q;

  // Parser state.
  phase_e           phase_q, phase_d;
  logic             hdr_array_q, hdr_array_d;
  logic             array_open_q, array_open_d;
  logic [6:0]       arg_count_q, arg_count_d;
  logic [6:0]       arg_pos_q, arg_pos_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [23:0]      remain_q, remain_d;
  logic [23:0]      cur_len_q, cur_len_d;
  err_e             err_q, err_d;

  // Helper values for the state update.
  logic [3:0]       digit;
  logic [ACC_W+3:0] acc_times10;
  logic [ACC_W+3:0] acc_sum;
  logic [ACC_W-1:0] acc_next;
  logic             is_digit;
  logic [LCNT_W:0]  lcnt_inc;
  logic             line_full;
  logic [6:0]       arg_limit;
  logic [6:0]       pos_inc;
  logic             last_arg;
  logic [23:0]      remain_dec;

  // A byte moves from the input register to the result register when the
  // result register is empty or being emptied.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
    end
  end

  // Limit registers; the user writes them only while the parser is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bulk_q <= MAX_BULK_LEN_RST;
      max_args_q <= MAX_ARGS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_BULK_LEN: max_bulk_q <= cfg_wdata_i;
        CFG_MAX_ARGS:     max_args_q <= cfg_wdata_i[6:0];
        default:          max_bulk_q <= max_bulk_q;
      endcase
    end
  end

  // Decimal accumulation with saturation, and the line length check.
  assign digit       = 4'(byte_q - CH_ZERO);
  assign is_digit    = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign acc_times10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum     = acc_times10 + {{(ACC_W){1'b0}}, digit};
  assign acc_next    = ((acc_q > ACC_CAP_DIV10) || (acc_sum > {4'b0000, ACC_CAP}))
                       ? ACC_CAP : acc_sum[ACC_W-1:0];
  assign lcnt_inc    = {1'b0, lcnt_q} + 1'b1;
  assign line_full   = lcnt_inc >= (LCNT_W+1)'(LEN_LINE_LIMIT);
  assign arg_limit   = (max_args_q < MAX_ARGS) ? max_args_q : MAX_ARGS;
  assign pos_inc     = arg_pos_q + 7'd1;
  assign last_arg    = pos_inc >= arg_count_q;
  assign remain_dec  = remain_q - 24'd1;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d      = phase_q;
    hdr_array_d  = hdr_array_q;
    array_open_d = array_open_q;
    arg_count_d  = arg_count_q;
    arg_pos_d    = arg_pos_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    lcnt_d       = lcnt_q;
    remain_d     = remain_q;
    cur_len_d    = cur_len_q;
    err_d        = err_q;
    res_d        = '0;
    res_d.kind   = KIND_NONE;

    if (err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_TYPE: begin
          if (byte_q == CH_STAR && !array_open_q) begin
            hdr_array_d = 1'b1;
            phase_d     = PH_LEN;
          end else if (byte_q == CH_DOLLAR && array_open_q) begin
            hdr_array_d = 1'b0;
            phase_d     = PH_LEN;
          end else if (byte_q == CH_DOLLAR) begin
            err_d = ERR_OUTSIDE_ARR;
          end else begin
            err_d = ERR_BAD_TYPE;
          end
          acc_d  = '0;
          neg_d  = 1'b0;
          lcnt_d = '0;
        end

        PH_LEN: begin
          if (byte_q == CH_CR) begin
            // End of the length line: range checks.
            if (hdr_array_q) begin
              if ((neg_q && acc_q != '0) || acc_q > {{(ACC_W-7){1'b0}}, arg_limit}) begin
                err_d = ERR_RANGE;
              end else begin
                neg_d   = 1'b0;
                phase_d = PH_LEN_LF;
              end
            end else if (neg_q && acc_q != '0) begin
              // Only minus one is allowed: a null argument ends here.
              if (acc_q != ACC_W'(1)) begin
                err_d = ERR_RANGE;
              end else begin
                cur_len_d     = '0;
                res_d.kind    = KIND_ARG_END;
                res_d.idx     = arg_pos_q[5:0];
                res_d.is_null = 1'b1;
                phase_d       = PH_LEN_LF;
              end
            end else begin
              if (acc_q > {1'b0, max_bulk_q}) begin
                err_d = ERR_RANGE;
              end else begin
                neg_d     = 1'b0;
                cur_len_d = acc_q[23:0];
                phase_d   = PH_LEN_LF;
              end
            end
          end else if (line_full) begin
            err_d = ERR_LINE_LONG;
          end else if (is_digit) begin
            acc_d  = acc_next;
            lcnt_d = lcnt_inc[LCNT_W-1:0];
          end else if ((byte_q == CH_MINUS || byte_q == CH_PLUS) && lcnt_q == '0) begin
            neg_d  = (byte_q == CH_MINUS);
            lcnt_d = lcnt_inc[LCNT_W-1:0];
          end else begin
            err_d = ERR_RANGE;
          end
        end

        PH_LEN_LF: begin
          if (byte_q != CH_LF) begin
            err_d = ERR_BAD_TERM;
          end else if (hdr_array_q) begin
            arg_count_d = acc_q[6:0];
            arg_pos_d   = '0;
            phase_d     = PH_TYPE;
            if (acc_q[6:0] == '0) begin
              res_d.kind = KIND_CMD_END;
            end else begin
              array_open_d = 1'b1;
            end
          end else if (neg_q) begin
            // Null argument: close it without a payload.
            neg_d   = 1'b0;
            phase_d = PH_TYPE;
            if (last_arg) begin
              array_open_d = 1'b0;
              arg_pos_d    = '0;
              res_d.kind   = KIND_CMD_END;
              res_d.total  = arg_count_q;
            end else begin
              arg_pos_d = pos_inc;
            end
          end else begin
            remain_d = cur_len_q;
            phase_d  = (cur_len_q == '0) ? PH_PAY_CR : PH_PAYLOAD;
          end
        end

        PH_PAYLOAD: begin
          res_d.kind = KIND_PAYLOAD;
          res_d.data = byte_q;
          res_d.idx  = arg_pos_q[5:0];
          res_d.len  = cur_len_q;
          remain_d   = remain_dec;
          if (remain_dec == '0) begin
            phase_d = PH_PAY_CR;
          end
        end

        PH_PAY_CR: begin
          if (byte_q != CH_CR) begin
            err_d = ERR_BAD_TERM;
          end else begin
            res_d.kind = KIND_ARG_END;
            res_d.idx  = arg_pos_q[5:0];
            res_d.len  = cur_len_q;
            phase_d    = PH_PAY_LF;
          end
        end

        PH_PAY_LF: begin
          if (byte_q != CH_LF) begin
            err_d = ERR_BAD_TERM;
          end else begin
            phase_d = PH_TYPE;
            if (last_arg) begin
              array_open_d = 1'b0;
              arg_pos_d    = '0;
              res_d.kind   = KIND_CMD_END;
              res_d.total  = arg_count_q;
            end else begin
              arg_pos_d = pos_inc;
            end
          end
        end

        default: begin
          phase_d = PH_TYPE;
        end
      endcase

      // A newly raised error replaces whatever result was prepared.
      if (err_d != ERR_NONE) begin
        res_d      = '0;
        res_d.kind = KIND_ERROR;
      end
    end

    res_d.err = err_d;
  end

  // Parser state, updated once per byte that moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      hdr_array_q  <= 1'b0;
      array_open_q <= 1'b0;
      arg_count_q  <= '0;
      arg_pos_q    <= '0;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      lcnt_q       <= '0;
      remain_q     <= '0;
      cur_len_q    <= '0;
      err_q        <= ERR_NONE;
    end else if (advance) begin
      phase_q      <= phase_d;
      hdr_array_q  <= hdr_array_d;
      array_open_q <= array_open_d;
      arg_count_q  <= arg_count_d;
      arg_pos_q    <= arg_pos_d;
      acc_q        <= acc_d;
      neg_q        <= neg_d;
      lcnt_q       <= lcnt_d;
      remain_q     <= remain_d;
      cur_len_q    <= cur_len_d;
      err_q        <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = res_q.kind;
  assign data_byte_o   = res_q.data;
  assign arg_index_o   = res_q.idx;
  assign arg_length_o  = res_q.len;
  assign arg_is_null_o = res_q.is_null;
  assign arg_total_o   = res_q.total;
  assign error_code_o  = res_q.err;

  // Once latched, an error code never changes until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |=> (err_q == $past(err_q)))
    else $error("latched error code changed");

  // After an error, every further byte yields a result of kind nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && err_q != ERR_NONE) |=> (res_q.kind == KIND_NONE))
    else $error("result other than nothing after an error");

  // An error beat always carries a nonzero error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == KIND_ERROR) |-> (res_q.err != ERR_NONE))
    else $error("error beat without an error code");

  // Inside an open array the argument position stays below the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    array_open_q |-> (arg_pos_q < arg_count_q && arg_count_q != '0))
    else $error("argument position beyond array count");

  // Input is only stalled while a result is held by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && in_valid_q))
    else $error("input stalled without a held result");

endmodule
`default_nettype wire
